>>> rtl/core/bfc_pkg.sv
// Shared constants and types for the buddy free/coalesce unit.
// No dependencies; used by every module in rtl/core except bfc_map_mem.
`default_nettype none

package bfc_pkg;

  // Default geometry of the frame space and the order range.
  localparam int unsigned FrameBitsDef  = 12;
  localparam int unsigned OrderCountDef = 11;

  // Fixed widths of the transaction fields.
  localparam int unsigned FrameW    = 12;
  localparam int unsigned OrderOutW = 4;
  localparam int unsigned CountW    = 13;

  typedef logic [CountW-1:0] count_t;

  // Sequencer states: issue a bitmap read, then evaluate the returned bit.
  typedef enum logic [1:0] {
    SeqIdle,
    SeqRead,
    SeqEval
  } seq_state_e;

endpackage

`default_nettype wire

>>> rtl/core/bfc_map_mem.sv
// Free bitmap memory: one bit per possible block, all orders packed together.
// Synchronous (registered) read, one write port, clearing sweep after reset.
// Depends on nothing outside this file.
`default_nettype none

module bfc_map_mem #(
  parameter int unsigned AddrW = 13
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic                  rd_data_o,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic             wr_data_i,
  output logic                  ready_o
);

  logic             mem_q [2**AddrW];
  logic             rd_data_q;
  logic             clr_act_q, clr_act_d;
  logic [AddrW-1:0] clr_addr_q, clr_addr_d;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic             wr_data;

  // The clearing sweep walks every entry once after reset.
  always_comb begin
    clr_act_d  = clr_act_q;
    clr_addr_d = clr_addr_q;
    if (clr_act_q) begin
      clr_addr_d = clr_addr_q + AddrW'(1);
      if (clr_addr_q == {AddrW{1'b1}}) begin
        clr_act_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_act_q  <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_act_q  <= clr_act_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // The sweep owns the write port while it runs.
  always_comb begin
    wr_en   = clr_act_q ? 1'b1 : wr_en_i;
    wr_addr = clr_act_q ? clr_addr_q : wr_addr_i;
    wr_data = clr_act_q ? 1'b0 : wr_data_i;
  end

  // Storage array and registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign ready_o   = !clr_act_q;

endmodule

`default_nettype wire

>>> rtl/core/bfc_count_file.sv
// Per-order free block counters, cleared by reset.
// One counter is read and updated per cycle. Depends on bfc_pkg.
`default_nettype none

module bfc_count_file #(
  parameter int unsigned OrderCount = bfc_pkg::OrderCountDef,
  parameter int unsigned OrderW     = $clog2(OrderCount)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [OrderW-1:0] idx_i,
  input  wire logic              upd_en_i,
  input  wire logic              upd_dec_i,
  output bfc_pkg::count_t        cnt_new_o
);

  bfc_pkg::count_t cnt_q [OrderCount];
  bfc_pkg::count_t cnt_new;

  // Counts wrap on both directions.
  always_comb begin
    if (upd_dec_i) begin
      cnt_new = cnt_q[idx_i] - bfc_pkg::CountW'(1);
    end else begin
      cnt_new = cnt_q[idx_i] + bfc_pkg::CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < OrderCount; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (upd_en_i) begin
      cnt_q[idx_i] <= cnt_new;
    end
  end

  assign cnt_new_o = cnt_new;

endmodule

`default_nettype wire

>>> rtl/core/bfc_seq.sv
// Coalescing sequencer: walks the orders, reads and updates the free bitmap.
// Drives bfc_map_mem and bfc_count_file. Depends on bfc_pkg.
`default_nettype none

module bfc_seq #(
  parameter int unsigned FrameBits  = bfc_pkg::FrameBitsDef,
  parameter int unsigned OrderCount = bfc_pkg::OrderCountDef,
  parameter int unsigned OrderW     = $clog2(OrderCount),
  parameter int unsigned AddrW      = FrameBits + 1
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  input  wire logic [bfc_pkg::FrameW-1:0]       frame_index_i,
  input  wire logic                             map_ready_i,
  output logic                                  busy,
  output logic                                  map_rd_en_o,
  output logic [AddrW-1:0]                      map_rd_addr_o,
  input  wire logic                             map_rd_data_i,
  output logic                                  map_wr_en_o,
  output logic [AddrW-1:0]                      map_wr_addr_o,
  output logic                                  map_wr_data_o,
  output logic [OrderW-1:0]                     cnt_idx_o,
  output logic                                  cnt_upd_en_o,
  output logic                                  cnt_upd_dec_o,
  input  bfc_pkg::count_t                       cnt_new_i,
  output logic                                  done_o,
  output logic [bfc_pkg::FrameW-1:0]            block_start_o,
  output logic [bfc_pkg::OrderOutW-1:0]         block_order_o,
  output bfc_pkg::count_t                       order_free_count_o
);

  // Highest order reachable by merging.
  localparam int unsigned Top = (OrderCount - 1 < FrameBits) ? OrderCount - 1 : FrameBits;

  bfc_pkg::seq_state_e state_q, state_d;
  logic [FrameBits-1:0]            start_q, start_d;
  logic [OrderW-1:0]               order_q, order_d;
  logic                            done_q, done_d;
  logic [bfc_pkg::FrameW-1:0]      out_start_q, out_start_d;
  logic [bfc_pkg::OrderOutW-1:0]   out_order_q, out_order_d;
  bfc_pkg::count_t                 out_count_q, out_count_d;

  logic [FrameBits-1:0] size_bit;
  logic [FrameBits-1:0] buddy;
  logic [AddrW-1:0]     order_base;
  logic [AddrW-1:0]     buddy_slot;
  logic [AddrW-1:0]     own_slot;
  logic                 merge;
  logic                 accept;

  // Bitmap addressing: order k starts at MAP_SIZE - 2^(AddrW-k).
  always_comb begin
    size_bit   = FrameBits'(1) << order_q;
    buddy      = start_q ^ size_bit;
    order_base = ~({AddrW{1'b1}} >> order_q);
    buddy_slot = order_base + AddrW'(buddy >> order_q);
    own_slot   = order_base + AddrW'(start_q >> order_q);
    merge      = (order_q < OrderW'(Top)) && map_rd_data_i;
    accept     = start && !busy;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bfc_pkg::SeqIdle: begin
        if (accept) begin
          state_d = bfc_pkg::SeqRead;
        end
      end
      bfc_pkg::SeqRead: begin
        state_d = bfc_pkg::SeqEval;
      end
      bfc_pkg::SeqEval: begin
        state_d = merge ? bfc_pkg::SeqRead : bfc_pkg::SeqIdle;
      end
      default: begin
        state_d = bfc_pkg::SeqIdle;
      end
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    start_d       = start_q;
    order_d       = order_q;
    done_d        = 1'b0;
    out_start_d   = out_start_q;
    out_order_d   = out_order_q;
    out_count_d   = out_count_q;
    map_rd_en_o   = 1'b0;
    map_rd_addr_o = buddy_slot;
    map_wr_en_o   = 1'b0;
    map_wr_addr_o = own_slot;
    map_wr_data_o = 1'b1;
    cnt_idx_o     = order_q;
    cnt_upd_en_o  = 1'b0;
    cnt_upd_dec_o = 1'b0;
    unique case (state_q)
      bfc_pkg::SeqIdle: begin
        if (accept) begin
          start_d = FrameBits'(frame_index_i);
          order_d = '0;
        end
      end
      bfc_pkg::SeqRead: begin
        map_rd_en_o = 1'b1;
      end
      bfc_pkg::SeqEval: begin
        cnt_upd_en_o = 1'b1;
        map_wr_en_o  = 1'b1;
        if (merge) begin
          // Take the buddy off its free map and climb one order.
          map_wr_addr_o = buddy_slot;
          map_wr_data_o = 1'b0;
          cnt_upd_dec_o = 1'b1;
          start_d       = start_q & ~size_bit;
          order_d       = order_q + OrderW'(1);
        end else begin
          // Mark the final block free and report it.
          done_d      = 1'b1;
          out_start_d = bfc_pkg::FrameW'(start_q);
          out_order_d = bfc_pkg::OrderOutW'(order_q);
          out_count_d = cnt_new_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfc_pkg::SeqIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q     <= start_d;
    order_q     <= order_d;
    out_start_q <= out_start_d;
    out_order_q <= out_order_d;
    out_count_q <= out_count_d;
  end

  assign busy               = (state_q != bfc_pkg::SeqIdle) || !map_ready_i;
  assign done_o             = done_q;
  assign block_start_o      = out_start_q;
  assign block_order_o      = out_order_q;
  assign order_free_count_o = out_count_q;

endmodule

`default_nettype wire

>>> rtl/core/buddy_free_coalesce_unit.sv
// Top level of the buddy free/coalesce unit.
// Instantiates bfc_seq, bfc_map_mem and bfc_count_file; depends on bfc_pkg.
`default_nettype none

// Frees one page frame per transaction into a buddy allocator and coalesces
// it with free buddies, order by order. A transaction is taken when start is
// high and busy is low. Each order examined takes a bitmap read, then the
// evaluate/update step; the registered read of the bitmap memory is paid
// again at every order. A free merges at most ten times with the default
// eleven orders. busy drops in the cycle that done_o is shown, so a new
// transaction is taken only once the previous result is shown.
// The result is on the output ports for exactly one cycle, marked by done_o,
// and cannot be stalled. After reset the bitmap is cleared by a sweep over all
// 2^(FRAME_BITS+1) entries (8192 by default) while busy stays high.
module buddy_free_coalesce_unit #(
  parameter int unsigned FRAME_BITS  = bfc_pkg::FrameBitsDef,
  parameter int unsigned ORDER_COUNT = bfc_pkg::OrderCountDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [bfc_pkg::FrameW-1:0]       frame_index_i,
  output logic                                  done_o,
  output logic [bfc_pkg::FrameW-1:0]            block_start_o,
  output logic [bfc_pkg::OrderOutW-1:0]         block_order_o,
  output logic [bfc_pkg::CountW-1:0]            order_free_count_o
);

  localparam int unsigned OrderW = $clog2(ORDER_COUNT);
  localparam int unsigned AddrW  = FRAME_BITS + 1;
  localparam int unsigned Top    =
    (ORDER_COUNT - 1 < FRAME_BITS) ? ORDER_COUNT - 1 : FRAME_BITS;

  logic              map_ready;
  logic              map_rd_en;
  logic [AddrW-1:0]  map_rd_addr;
  logic              map_rd_data;
  logic              map_wr_en;
  logic [AddrW-1:0]  map_wr_addr;
  logic              map_wr_data;
  logic [OrderW-1:0] cnt_idx;
  logic              cnt_upd_en;
  logic              cnt_upd_dec;
  bfc_pkg::count_t   cnt_new;

  // Sequencer.
  bfc_seq #(
    .FrameBits  (FRAME_BITS),
    .OrderCount (ORDER_COUNT),
    .OrderW     (OrderW),
    .AddrW      (AddrW)
  ) u_seq (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .frame_index_i      (frame_index_i),
    .map_ready_i        (map_ready),
    .busy               (busy),
    .map_rd_en_o        (map_rd_en),
    .map_rd_addr_o      (map_rd_addr),
    .map_rd_data_i      (map_rd_data),
    .map_wr_en_o        (map_wr_en),
    .map_wr_addr_o      (map_wr_addr),
    .map_wr_data_o      (map_wr_data),
    .cnt_idx_o          (cnt_idx),
    .cnt_upd_en_o       (cnt_upd_en),
    .cnt_upd_dec_o      (cnt_upd_dec),
    .cnt_new_i          (cnt_new),
    .done_o             (done_o),
    .block_start_o      (block_start_o),
    .block_order_o      (block_order_o),
    .order_free_count_o (order_free_count_o)
  );

  // Free bitmap.
  bfc_map_mem #(
    .AddrW (AddrW)
  ) u_map_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (map_rd_en),
    .rd_addr_i (map_rd_addr),
    .rd_data_o (map_rd_data),
    .wr_en_i   (map_wr_en),
    .wr_addr_i (map_wr_addr),
    .wr_data_i (map_wr_data),
    .ready_o   (map_ready)
  );

  // Per-order counters.
  bfc_count_file #(
    .OrderCount (ORDER_COUNT),
    .OrderW     (OrderW)
  ) u_count_file (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .idx_i     (cnt_idx),
    .upd_en_i  (cnt_upd_en),
    .upd_dec_i (cnt_upd_dec),
    .cnt_new_o (cnt_new)
  );

  // An accepted transaction keeps the unit busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("unit not busy after accepting a transaction");

  // A result appears only once the unit has gone idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // Results are single-cycle strobes.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // Merging never climbs past the top order.
  a_order_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (block_order_o <= bfc_pkg::OrderOutW'(Top)))
    else $error("result order beyond top order");

endmodule

`default_nettype wire
